@@ design/tlv8fx_pkg.sv @@
`timescale 1ns / 1ps
package tlv8fx_pkg;

  localparam int unsigned CapW = 11;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_DUP       = 3'd3,
    ST_OVER      = 3'd4
  } status_t;

  typedef enum logic {
    CFG_WANTED_TYPE = 1'b0,
    CFG_CAPACITY    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    phase_t            phase;
    logic [7:0]        bytes_left;
    logic              record_matches;
    logic              field_found;
    logic              prior_full;
    logic [CapW-1:0]   bytes_used;
    status_t           error_code;
  } msg_state_t;

  typedef struct packed {
    logic              emit;
    logic              data_valid;
    logic [7:0]        data_out;
    logic              done_res;
    status_t           status;
    logic [CapW-1:0]   total_length;
  } result_t;

  localparam msg_state_t MsgClear = '{
    phase:          PH_TYPE,
    bytes_left:     8'd0,
    record_matches: 1'b0,
    field_found:    1'b0,
    prior_full:     1'b0,
    bytes_used:     '0,
    error_code:     ST_OK
  };

endpackage

@@ design/tlv8_field_extractor_unit.sv @@
`timescale 1ns / 1ps
// TLV8 field extractor.
// in_*: one message byte per request, in_tlast on the final byte.
// out_*: one request per extracted payload byte (out_tuser = 1) and one on
//   the final byte (out_tlast = 1) with status and total length; a byte that
//   is both gives a single request. Other bytes give no output request.
// cfg_*: register writes, index 0 wanted type, index 1 capacity. Write only
//   while no message is in flight.
// A result reaches out_* through the output register, or through the skid entry first when the output register is full.
// Throughput: one byte per cycle while in_tready is high. The whole parse step is one level of
//   logic from the accepted byte to the state and output registers.
// A two-entry output buffer (output register plus skid entry) keeps
//   in_tready high while one result waits; with both entries full,
//   in_tready drops until out_tready takes one.
// Reset: wanted type 0, capacity 1024, parser at a type byte, buffer empty.
// After a status request the parser is back at a type byte; the registers
//   keep their values.
module tlv8_field_extractor_unit
  import tlv8fx_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_out, [10:8] status, [21:11] total_length
  output logic        out_tuser,  // data_valid
  output logic        out_tlast,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam logic [16:0] MaxCap = 17'(MAX_CAPACITY);

  logic [7:0]      wanted_type_r;
  logic [CapW-1:0] capacity_r;
  logic [CapW-1:0] limit;
  msg_state_t      st_r, st_nxt;
  result_t         res;
  result_t         out_res_r, skid_res_r;
  logic            out_v_r, skid_v_r;
  logic            in_take, out_take, push;

  assign cfg_ready = 1'b1;
  assign limit = ({6'd0, capacity_r} < MaxCap) ? capacity_r : MaxCap[CapW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r <= 8'd0;
      capacity_r    <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WANTED_TYPE: wanted_type_r <= cfg_data[7:0];
        CFG_CAPACITY:    capacity_r    <= cfg_data;
        default:         ;
      endcase
    end
  end

  tlv8fx_step u_step (
    .st          (st_r),
    .wanted_type (wanted_type_r),
    .limit       (limit),
    .byte_in     (in_tdata),
    .last_byte   (in_tlast),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  assign in_tready = !skid_v_r;
  assign in_take   = in_tvalid && in_tready;
  assign push      = in_take && res.emit;
  assign out_take  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MsgClear;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_take) begin
      out_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_v_r || out_take) begin
      out_res_r <= res;
    end else if (push) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.data_valid;
  assign out_tlast  = out_res_r.done_res;
  assign out_tdata  = {2'b00, out_res_r.total_length, out_res_r.status, out_res_r.data_out};

endmodule

@@ design/tlv8fx_step.sv @@
`timescale 1ns / 1ps
module tlv8fx_step
  import tlv8fx_pkg::*;
(
  input  msg_state_t      st,
  input  logic [7:0]      wanted_type,
  input  logic [CapW-1:0] limit,
  input  logic [7:0]      byte_in,
  input  logic            last_byte,
  output msg_state_t      st_nxt,
  output result_t         res
);

  msg_state_t       nx;
  logic [CapW-1:0]  room;
  logic             emit_byte;

  assign room = (st.bytes_used < limit) ? (limit - st.bytes_used) : '0;
  assign emit_byte = (st.error_code == ST_OK) && (st.phase == PH_PAY) && st.record_matches;

  // next message state
  always_comb begin
    nx = st;
    if (st.error_code == ST_OK) begin
      unique case (st.phase)
        PH_LEN: begin
          if (st.record_matches) begin
            if (st.field_found && !st.prior_full) begin
              nx.error_code = ST_DUP;
            end else if ({3'b000, byte_in} > room) begin
              nx.error_code = ST_OVER;
            end else begin
              nx.field_found = 1'b1;
            end
          end
          nx.prior_full = st.record_matches && (byte_in == 8'hFF);
          nx.bytes_left = byte_in;
          nx.phase = (byte_in != 8'd0) ? PH_PAY : PH_TYPE;
        end
        PH_PAY: begin
          if (st.record_matches) begin
            nx.bytes_used = st.bytes_used + CapW'(1);
          end
          nx.bytes_left = st.bytes_left - 8'd1;
          if (st.bytes_left == 8'd1) begin
            nx.phase = PH_TYPE;
          end
        end
        default: begin
          nx.record_matches = (byte_in == wanted_type);
          nx.phase = PH_LEN;
        end
      endcase
      if (last_byte && (nx.error_code == ST_OK) && (nx.phase != PH_TYPE)) begin
        nx.error_code = ST_TRUNC;
      end
    end
    st_nxt = last_byte ? MsgClear : nx;
  end

  // result for this byte
  always_comb begin
    res = '0;
    res.emit = emit_byte || last_byte;
    res.data_valid = emit_byte;
    res.data_out = emit_byte ? byte_in : 8'd0;
    res.done_res = last_byte;
    if (last_byte) begin
      if (nx.error_code != ST_OK) begin
        res.status = nx.error_code;
      end else if (nx.field_found) begin
        res.status = ST_OK;
        res.total_length = nx.bytes_used;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
  end

endmodule
